>>> rtl/cdtp_pkg.sv
// Package for the countdown timer pool: request codes, sequencer states,
// widths and constants. No dependencies.
package cdtp_pkg;

	localparam int DEF_NUM_TIMERS = 4;
	localparam int MAX_NUM_TIMERS = 16;

	localparam int REQ_W   = 2;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 16;

	// stream word widths, padded to whole bytes
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_NONE = 16'hffff;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 2'd0,
		REQ_ALLOC   = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,    // waiting for a request word
		ST_WALK,    // tick / allocate: one slot per cycle
		ST_SINGLE,  // release / read: one addressed slot
		ST_DONE     // result ready, waiting for the output register
	} state_t;

endpackage

>>> rtl/countdown_timer_pool_top.sv
// Countdown timer pool, top level: request sequencer, slot storage and the
// shared slot read / decrement unit. Depends on cdtp_pkg.
//
// A pool of NUM_TIMERS one-shot millisecond countdown timers driven by one
// request word at a time (tick, allocate, release, read count); every request
// gives exactly one result word. The block holds one request at a time:
// s_axis_tready is high only while the sequencer is idle. A single slot port
// (one count read mux, one decrementer / zero compare, one write port) is
// walked over the slots, one slot per cycle: a tick walks every slot, an
// allocate stops at the first idle slot, and a release or read touches only
// the addressed slot. Results go into an output register, so a new request
// is taken while the previous result still waits on m_axis_tready; a second
// result waits in the sequencer until that register frees. Reset clears all
// slots to idle with count zero.
module countdown_timer_pool_top #(
	parameter int NUM_TIMERS = cdtp_pkg::DEF_NUM_TIMERS  // 1 .. 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [1:0] req_type, [5:2] slot_index, [21:6] load_count, [23:22] zero
	input  logic [cdtp_pkg::S_DATA_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [3:0] granted_slot, [19:4] count_value, [20] failed, [23:21] zero
	output logic [cdtp_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import cdtp_pkg::*;

	// slot address width; at least one bit so a single-timer pool still builds
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_TIMERS - 1);
	localparam logic [SLOT_W:0]   NUM_EXT  = (SLOT_W + 1)'(NUM_TIMERS);

	// request latched at accept
	req_t               req_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [COUNT_W-1:0] load_q;

	// slot storage
	logic [NUM_TIMERS-1:0] busy_q;
	logic [COUNT_W-1:0]    cnt_q [NUM_TIMERS];

	// sequencer
	state_t           state_q, state_d;
	logic [IDX_W-1:0] walk_q, walk_d;

	// pending result
	logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
	logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;
	logic               res_fail_q, res_fail_d;
	logic               res_ld;

	// output register
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic                out_ld;

	// slot write port
	logic               wr_en;
	logic               wr_busy;
	logic [COUNT_W-1:0] wr_cnt;

	// shared slot unit: one read, one decrement, one zero compare
	logic [IDX_W-1:0]   rd_idx;
	logic               rd_busy;
	logic [COUNT_W-1:0] rd_cnt;
	logic [COUNT_W-1:0] rd_dec;
	logic               rd_zero;
	logic               idx_ok;
	logic               in_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign idx_ok  = ({1'b0, idx_q} < NUM_EXT);
	assign rd_idx  = (state_q == ST_WALK) ? walk_q : idx_q[IDX_W-1:0];
	assign rd_busy = busy_q[rd_idx];
	assign rd_cnt  = cnt_q[rd_idx];
	assign rd_dec  = rd_cnt - 1'b1;
	assign rd_zero = (rd_cnt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		walk_d        = walk_q;
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		wr_busy       = 1'b0;
		wr_cnt        = '0;
		res_ld        = 1'b0;
		res_slot_d    = '0;
		res_cnt_d     = '0;
		res_fail_d    = 1'b0;
		out_ld        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				walk_d        = '0;
				if (s_axis_tvalid) begin
					if (req_t'(s_axis_tdata[1:0]) == REQ_TICK ||
					    req_t'(s_axis_tdata[1:0]) == REQ_ALLOC) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_SINGLE;
					end
				end
			end
			ST_WALK: begin
				if (req_q == REQ_TICK) begin
					// saturating decrement of busy slots
					if (rd_busy && !rd_zero) begin
						wr_en   = 1'b1;
						wr_busy = 1'b1;
						wr_cnt  = rd_dec;
					end
					if (walk_q == LAST_IDX) begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end else begin
						walk_d = walk_q + 1'b1;
					end
				end else begin
					// allocate: first idle slot wins
					if (!rd_busy) begin
						wr_en      = 1'b1;
						wr_busy    = 1'b1;
						wr_cnt     = load_q;
						res_ld     = 1'b1;
						res_slot_d = SLOT_W'(walk_q);
						state_d    = ST_DONE;
					end else if (walk_q == LAST_IDX) begin
						res_ld     = 1'b1;
						res_fail_d = 1'b1;
						state_d    = ST_DONE;
					end else begin
						walk_d = walk_q + 1'b1;
					end
				end
			end
			ST_SINGLE: begin
				res_ld  = 1'b1;
				state_d = ST_DONE;
				if (req_q == REQ_RELEASE) begin
					wr_en = idx_ok;
				end else begin
					res_cnt_d = (idx_ok && rd_busy) ? rd_cnt : COUNT_NONE;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture and walk index
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_t'(s_axis_tdata[1:0]);
			idx_q  <= s_axis_tdata[5:2];
			load_q <= s_axis_tdata[21:6];
		end
		walk_q <= walk_d;
	end

	// slot storage, one write per cycle at rd_idx
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (wr_en) begin
			busy_q[rd_idx] <= wr_busy;
			cnt_q[rd_idx]  <= wr_cnt;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_slot_q <= res_slot_d;
			res_cnt_q  <= res_cnt_d;
			res_fail_q <= res_fail_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_data_q <= {3'b000, res_fail_q, res_cnt_q, res_slot_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/cdtp_checker.sv
// Port-level checks for the countdown timer pool, bound to the top level.
// Depends on cdtp_pkg and countdown_timer_pool_top.
module cdtp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [cdtp_pkg::S_DATA_W-1:0] s_axis_tdata,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [cdtp_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import cdtp_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in work");

	// a new result is loaded only from the busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without work");

	// a failed allocate reports slot 0 and count 0
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:0] == '0)
		else $error("failed result carries slot or count");

endmodule

bind countdown_timer_pool_top cdtp_checker u_cdtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

>>> bench/countdown_timer_pool_checker.sv
`timescale 1ns / 100ps
// Countdown timer pool checker: watches both stream channels, tracks the slot
// state itself and compares every result word in order. Depends on cdtp_pkg.
module countdown_timer_pool_checker #(
	parameter int NUM_TIMERS = cdtp_pkg::DEF_NUM_TIMERS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [cdtp_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [cdtp_pkg::M_DATA_W-1:0] m_axis_tdata,
	output int                            mismatches,
	output int                            pending,
	output int                            words_checked,
	output int                            full_refusals,
	output int                            zero_reads
);
	import cdtp_pkg::*;

	// result word, lowest bits first: slot, count, failed, zero fill
	typedef struct packed {
		logic [2:0]         pad;
		logic               failed;
		logic [COUNT_W-1:0] count;
		logic [SLOT_W-1:0]  slot;
	} pool_result_t;

	logic               timer_busy [NUM_TIMERS];
	logic [COUNT_W-1:0] timer_left [NUM_TIMERS];
	pool_result_t       expected_q [$];
	int                 n_bad = 0;
	int                 n_checked = 0;
	int                 n_refused = 0;
	int                 n_zero_reads = 0;

	assign mismatches    = n_bad;
	assign words_checked = n_checked;
	assign full_refusals = n_refused;
	assign zero_reads    = n_zero_reads;

	// applies one request to the slot copy and returns the result it owes
	function automatic pool_result_t apply_request(input logic [S_DATA_W-1:0] w);
		req_t               req;
		logic [SLOT_W-1:0]  idx;
		logic [COUNT_W-1:0] load;
		pool_result_t       r;
		req  = req_t'(w[1:0]);
		idx  = w[5:2];
		load = w[21:6];
		r    = '0;
		case (req)
		REQ_TICK: begin
			for (int i = 0; i < NUM_TIMERS; i++)
				if (timer_busy[i] && timer_left[i] != '0)
					timer_left[i] = timer_left[i] - 1'b1;
		end
		REQ_ALLOC: begin
			r.failed = 1'b1;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (r.failed && !timer_busy[i]) begin
					timer_busy[i] = 1'b1;
					timer_left[i] = load;
					r.slot        = SLOT_W'(i);
					r.failed      = 1'b0;
				end
			end
			if (r.failed)
				n_refused++;
		end
		REQ_RELEASE: begin
			if (idx < NUM_TIMERS) begin
				timer_busy[idx] = 1'b0;
				timer_left[idx] = '0;
			end
		end
		default: begin
			r.count = COUNT_NONE;
			if (idx < NUM_TIMERS && timer_busy[idx]) begin
				r.count = timer_left[idx];
				if (timer_left[idx] == '0)
					n_zero_reads++;
			end
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_result_t got;
		pool_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				timer_busy[i] = 1'b0;
				timer_left[i] = '0;
			end
			expected_q.delete();
			pending <= 0;
		end else begin
			// output first: a result can never belong to a word taken this edge
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_q.size() == 0) begin
					n_bad++;
					$display("%0t: unexpected result word, expected none, got %h", $time, got);
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (got.slot !== want.slot) begin
						n_bad++;
						$display("%0t: granted_slot expected %0d, got %0d",
							$time, want.slot, got.slot);
					end
					if (got.count !== want.count) begin
						n_bad++;
						$display("%0t: count_value expected %h, got %h",
							$time, want.count, got.count);
					end
					if (got.failed !== want.failed) begin
						n_bad++;
						$display("%0t: failed expected %b, got %b",
							$time, want.failed, got.failed);
					end
					if (got.pad !== want.pad) begin
						n_bad++;
						$display("%0t: fill bits expected %b, got %b",
							$time, want.pad, got.pad);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(apply_request(s_axis_tdata));
			pending <= expected_q.size();
		end
	end

endmodule

>>> bench/tb_countdown_timer_pool_top.sv
`timescale 1ns / 100ps
// Testbench top for the countdown timer pool: drives request words, stalls the
// result side and gives the verdict. Depends on cdtp_pkg, the pool top and its checker.
module tb_countdown_timer_pool_top;
	import cdtp_pkg::*;

	localparam int NUM_TIMERS       = DEF_NUM_TIMERS;
	localparam int RANDOM_WORDS     = 550;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int HOLD_AT_WORD     = 100;  // random word at which the long hold starts
	localparam int DRAIN_AT_WORD    = 320;  // random word before which the sender drains
	localparam int SETTLE_CYCLES    = 20;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,    // always ready
		RX_COIN,    // ready half the time
		RX_SPARSE   // ready one cycle in six
	} rx_mode_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// [1:0] req_type, [5:2] slot_index, [21:6] load_count, [23:22] zero
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [3:0] granted_slot, [19:4] count_value, [20] failed, [23:21] zero
	logic [M_DATA_W-1:0] m_axis_tdata;

	int   mismatches;
	int   pending;
	int   words_checked;
	int   full_refusals;
	int   zero_reads;
	int   req_seen [4] = '{default: 0};
	int   burst_left   = 0;
	logic long_hold_req = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	countdown_timer_pool_top #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	countdown_timer_pool_checker #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.pending      (pending),
		.words_checked(words_checked),
		.full_refusals(full_refusals),
		.zero_reads   (zero_reads)
	);

	function automatic logic [S_DATA_W-1:0] pack_request(input req_t kind,
			input logic [SLOT_W-1:0] idx, input logic [COUNT_W-1:0] load);
		return {2'b00, load, idx, kind};
	endfunction

	// Offers one word and holds it until taken. Words go out in bursts; at the
	// end of a burst valid drops for a random gap (sometimes none at all).
	task automatic offer_word(input logic [S_DATA_W-1:0] w);
		int gap;
		s_axis_tdata  <= w;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		req_seen[w[1:0]]++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Result side: runs of random length in one stall pattern, plus a single
	// long hold-off so the output register and sequencer both fill and the
	// block drops s_axis_tready while the sender keeps offering.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		logic     hold_used;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_used) begin
				hold_used = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
				RX_OPEN:  m_axis_tready <= 1'b1;
				RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
				default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Stimulus: reset, a directed pass over the corner cases, then random words.
	initial begin
		int                 pick;
		req_t               kind;
		logic [SLOT_W-1:0]  idx;
		logic [COUNT_W-1:0] load;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle and out-of-range reads, releases that must do nothing,
		// tick with junk in the unused fields
		offer_word(pack_request(REQ_READ,    4'd0,  16'h0000));
		offer_word(pack_request(REQ_READ,    4'd15, 16'hffff));
		offer_word(pack_request(REQ_RELEASE, 4'd2,  16'h1234));
		offer_word(pack_request(REQ_RELEASE, 4'd15, 16'hffff));
		offer_word(pack_request(REQ_TICK,    4'd15, 16'hffff));
		// fill the pool, extremes of load_count, then one allocate too many
		offer_word(pack_request(REQ_ALLOC,   4'd15, 16'h0000));
		offer_word(pack_request(REQ_ALLOC,   4'd0,  16'hffff));
		offer_word(pack_request(REQ_ALLOC,   4'd9,  16'h0001));
		offer_word(pack_request(REQ_ALLOC,   4'd3,  16'h0002));
		offer_word(pack_request(REQ_ALLOC,   4'd1,  16'h0005));
		// counts run into zero and must stay there while busy
		offer_word(pack_request(REQ_TICK,    4'd0,  16'h0000));
		offer_word(pack_request(REQ_READ,    4'd0,  16'hffff));
		offer_word(pack_request(REQ_READ,    4'd1,  16'h0000));
		offer_word(pack_request(REQ_READ,    4'd2,  16'h0000));
		offer_word(pack_request(REQ_TICK,    4'd7,  16'hbeef));
		offer_word(pack_request(REQ_READ,    4'd3,  16'h0000));
		offer_word(pack_request(REQ_READ,    4'd4,  16'h0000));
		// release and reclaim a middle slot
		offer_word(pack_request(REQ_RELEASE, 4'd1,  16'h0000));
		offer_word(pack_request(REQ_READ,    4'd1,  16'h0000));
		offer_word(pack_request(REQ_ALLOC,   4'd5,  16'h8000));
		offer_word(pack_request(REQ_READ,    4'd1,  16'h0000));
		// empty the pool again
		offer_word(pack_request(REQ_RELEASE, 4'd0,  16'h0000));
		offer_word(pack_request(REQ_RELEASE, 4'd2,  16'h0000));
		offer_word(pack_request(REQ_RELEASE, 4'd3,  16'h0000));
		offer_word(pack_request(REQ_RELEASE, 4'd1,  16'h0000));

		// Random part: ticks and small loads so timers actually expire, enough
		// allocates to keep the pool full often, mostly in-range slot indexes.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == HOLD_AT_WORD)
				long_hold_req <= 1'b1;
			if (n == DRAIN_AT_WORD) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 30)
				kind = REQ_TICK;
			else if (pick < 55)
				kind = REQ_ALLOC;
			else if (pick < 75)
				kind = REQ_RELEASE;
			else
				kind = REQ_READ;
			if ($urandom_range(0, 4) == 0)
				idx = SLOT_W'($urandom_range(0, 15));
			else
				idx = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
			pick = $urandom_range(0, 19);
			if (pick < 12)
				load = COUNT_W'($urandom_range(0, 6));
			else if (pick < 17)
				load = COUNT_W'($urandom_range(0, 400));
			else
				load = COUNT_W'($urandom());
			offer_word(pack_request(kind, idx, load));
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d ticks, %0d allocates, %0d releases, %0d reads; %0d results checked.",
			req_seen[REQ_TICK] + req_seen[REQ_ALLOC] + req_seen[REQ_RELEASE]
			+ req_seen[REQ_READ], req_seen[REQ_TICK], req_seen[REQ_ALLOC],
			req_seen[REQ_RELEASE], req_seen[REQ_READ], words_checked);
		$display("Allocates refused on a full pool: %0d, reads of expired timers: %0d, one long output hold and one full drain.",
			full_refusals, zero_reads);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog: fails the run if it does not finish in time
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
